@@ src/modular_exponentiation_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Modular exponentiation unit: assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Default width and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned OperandWidth = 32;

  typedef struct packed {
    logic load_in;        // capture a new word and reset the accumulator
    logic reduce_step;    // one bit of base reduction
    logic mul_start_acc;  // begin accumulator times power
    logic mul_start_sqr;  // begin power squared
    logic mul_step;       // one bit of shift-and-add multiplication
    logic commit_acc;     // product into the accumulator
    logic commit_sqr;     // product into the power, exponent shifts right
    logic load_out;       // accumulator into the output register
  } mexp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
  } mexp_status_t;

endpackage

@@ src/mexp_dp.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Modulus register, base reduction by restoring remainder, and a shared
// shift-and-add modular multiplier with one operand bit per cycle.
// ----------------------------------------------------------------------------
module mexp_dp import mexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     modulus_we_i,
  input  logic [OPERAND_WIDTH-1:0] modulus_i,
  input  logic [OPERAND_WIDTH-1:0] base_value_i,
  input  logic [OPERAND_WIDTH-1:0] exponent_i,
  input  mexp_cmd_t                cmd_i,
  output mexp_status_t             status_o,
  output logic [OPERAND_WIDTH-1:0] power_result_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic [W-1:0] mod_q,  mod_d;
  logic [W-1:0] base_q, base_d;
  logic [W-1:0] exp_q,  exp_d;
  logic [W-1:0] pow_q,  pow_d;
  logic [W-1:0] acc_q,  acc_d;
  logic [W-1:0] mul_a_q, mul_a_d;
  logic [W-1:0] mul_b_q, mul_b_d;
  logic [W-1:0] mul_p_q, mul_p_d;
  logic [W-1:0] out_q,  out_d;

  logic [W:0] rem_ext;
  logic [W:0] rem_sub;
  logic [W:0] sum_add;
  logic [W:0] sum_dbl;
  logic [W:0] mod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= W'(2);
    end else begin
      mod_q <= mod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    exp_q   <= exp_d;
    pow_q   <= pow_d;
    acc_q   <= acc_d;
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    mul_p_q <= mul_p_d;
    out_q   <= out_d;
  end

  always_comb begin
    mod_ext = {1'b0, mod_q};
    rem_ext = {pow_q, base_q[W-1]};
    rem_sub = rem_ext - mod_ext;
    // Both operands stay below the modulus, so one subtraction restores it.
    sum_add = {1'b0, mul_p_q} + {1'b0, mul_a_q};
    sum_dbl = {1'b0, mul_a_q} + {1'b0, mul_a_q};

    mod_d   = mod_q;
    base_d  = base_q;
    exp_d   = exp_q;
    pow_d   = pow_q;
    acc_d   = acc_q;
    mul_a_d = mul_a_q;
    mul_b_d = mul_b_q;
    mul_p_d = mul_p_q;
    out_d   = out_q;

    if (modulus_we_i) begin
      mod_d = (modulus_i < W'(2)) ? W'(2) : modulus_i;
    end

    if (cmd_i.load_in) begin
      base_d = base_value_i;
      exp_d  = exponent_i;
      pow_d  = '0;
      acc_d  = W'(1);
    end

    if (cmd_i.reduce_step) begin
      base_d = {base_q[W-2:0], 1'b0};
      pow_d  = (rem_ext >= mod_ext) ? rem_sub[W-1:0] : rem_ext[W-1:0];
    end

    if (cmd_i.mul_start_acc || cmd_i.mul_start_sqr) begin
      mul_a_d = pow_q;
      mul_b_d = cmd_i.mul_start_sqr ? pow_q : acc_q;
      mul_p_d = '0;
    end

    if (cmd_i.mul_step) begin
      if (mul_b_q[0]) begin
        mul_p_d = (sum_add >= mod_ext) ? W'(sum_add - mod_ext) : sum_add[W-1:0];
      end
      mul_a_d = (sum_dbl >= mod_ext) ? W'(sum_dbl - mod_ext) : sum_dbl[W-1:0];
      mul_b_d = {1'b0, mul_b_q[W-1:1]};
    end

    if (cmd_i.commit_acc) begin
      acc_d = mul_p_q;
    end

    if (cmd_i.commit_sqr) begin
      pow_d = mul_p_q;
      exp_d = {1'b0, exp_q[W-1:1]};
    end

    if (cmd_i.load_out) begin
      out_d = acc_q;
    end
  end

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_lsb  = exp_q[0];
  assign power_result_o    = out_q;

endmodule

@@ src/mexp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences reduction, the exponent bit walk and up to two multiplications
// per bit, and holds the output word until it is taken.
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  mexp_status_t status_i,
  output mexp_cmd_t    cmd_o
);

  localparam int unsigned CntW = $clog2(OPERAND_WIDTH);

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StCheck,
    StMulAcc,
    StAccWb,
    StMulSqr,
    StSqrWb,
    StFinish
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = CntW'(OPERAND_WIDTH - 1);
          state_d       = StReduce;
        end
      end
      StReduce: begin
        cmd_o.reduce_step = 1'b1;
        cnt_d             = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        cnt_d = CntW'(OPERAND_WIDTH - 1);
        if (status_i.exp_zero) begin
          state_d = StFinish;
        end else if (status_i.exp_lsb) begin
          cmd_o.mul_start_acc = 1'b1;
          state_d             = StMulAcc;
        end else begin
          cmd_o.mul_start_sqr = 1'b1;
          state_d             = StMulSqr;
        end
      end
      StMulAcc: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StAccWb;
        end
      end
      StAccWb: begin
        // The squaring reads the power, which the write-back leaves alone.
        cmd_o.commit_acc    = 1'b1;
        cmd_o.mul_start_sqr = 1'b1;
        cnt_d               = CntW'(OPERAND_WIDTH - 1);
        state_d             = StMulSqr;
      end
      StMulSqr: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StSqrWb;
        end
      end
      StSqrWb: begin
        cmd_o.commit_sqr = 1'b1;
        state_d          = StCheck;
      end
      StFinish: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/modular_exponentiation_unit.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Right-to-left binary square and multiply modulo a configured modulus.
//
//   Channel   Signals                               Direction
//   input     in_valid_i, in_ready_o,               in
//             base_value_i, exponent_i
//   output    out_valid_o, out_ready_i,             out
//             power_result_o
//   config    modulus_we_i, modulus_i               in
//
// A word is loaded and its base reduced bit by bit, then each exponent bit
// up to the highest set one runs a multiply into the accumulator when set
// and a squaring of the power in either case, both on the shared bit-serial
// modular multiplier, and a finish state writes the result out.
// Reset leaves the modulus at two and no word in flight.
// A new word is taken while the last result waits; only the finish stalls.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_defines.svh"

module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     modulus_we_i,
  input  logic [OPERAND_WIDTH-1:0] modulus_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OPERAND_WIDTH-1:0] base_value_i,
  input  logic [OPERAND_WIDTH-1:0] exponent_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OPERAND_WIDTH-1:0] power_result_o
);

  mexp_cmd_t    cmd;
  mexp_status_t status;
  logic [3:0]   dp_ops;

  mexp_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mexp_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .modulus_we_i  (modulus_we_i),
    .modulus_i     (modulus_i),
    .base_value_i  (base_value_i),
    .exponent_i    (exponent_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .power_result_o(power_result_o)
  );

  assign dp_ops = {cmd.load_in, cmd.reduce_step, cmd.mul_step, cmd.load_out};

  // An accepted word keeps the unit busy for at least the next cycle.
  `MEXP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready too soon")
  // The result is only written out once every exponent bit has been used.
  `MEXP_ASSERT(a_out_after_exp, !cmd.load_out || status.exp_zero, "result before exponent done")
  // Load, reduction, multiplication and output never overlap.
  `MEXP_ASSERT(a_cmd_exclusive, $onehot0(dp_ops), "overlapping datapath commands")

endmodule
